@@ src/keyed_list_table_insert_remove_search_unit_macros.svh @@
// Assertion macros for the keyed list table unit.
// Used by the port-level checker; depends on nothing else.
`ifndef KEYED_LIST_TABLE_INSERT_REMOVE_SEARCH_UNIT_MACROS_SVH
`define KEYED_LIST_TABLE_INSERT_REMOVE_SEARCH_UNIT_MACROS_SVH

// Property checked outside reset.
`define KLT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define KLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/klt_pkg.sv @@
// Shared types and constants of the keyed list table unit.
// Used by klt_cell, the top level and the checker; no dependencies.
package klt_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int KEY_BITS_DEF = 64;

  localparam int ACTION_W = 2;
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;
  localparam int IN_W     = 72;   // action + key, padded to bytes
  localparam int OUT_W    = 16;   // status + position, padded to bytes

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_MATCH     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_INS  = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  // per-cell controls
  typedef struct packed {
    logic load;     // take the broadcast key
    logic shift;    // take the upper neighbor's key
    logic capture;  // latch the compare result
    logic advance;  // take the upper neighbor's match flag
  } cell_ctl_t;

endpackage

@@ src/klt_cell.sv @@
// One table cell: a stored key plus a match flag, both shiftable from the
// upper neighbor. Depends on klt_pkg.
module klt_cell #(
  parameter int KEY_BITS = klt_pkg::KEY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  klt_pkg::cell_ctl_t   ctl,
  input  logic                 valid,
  input  logic [KEY_BITS-1:0]  cmp_key,
  input  logic [KEY_BITS-1:0]  nbr_key,
  input  logic                 nbr_flag,
  output logic [KEY_BITS-1:0]  key,
  output logic                 flag
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key <= cmp_key;
    end else if (ctl.shift) begin
      key <= nbr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctl.capture) begin
      flag <= valid && (key == cmp_key);
    end else if (ctl.advance) begin
      flag <= nbr_flag;
    end
  end

endmodule

@@ src/keyed_list_table_insert_remove_search_unit.sv @@
// Keyed list table: top level with the control sequencer and the cell chain.
// Depends on klt_pkg and klt_cell.
//
// Input channel s_*: one item = action (insert, remove, search) and a key.
// Output channel m_*: status and position in tdata, tlast on the final
// result of an item.
// Insert: one result (added at the end of the table, or table full).
// Remove and search: match flags of all cells are latched when the item is
// taken, then shift down the chain one position per cycle, unless the
// receiver stalls, while cell 0's flag is examined. A remove stops at the
// first match and closes the gap by shifting all cells above it down one
// position together; a search gives one result per match.
// A new item is taken only in idle, even while the last result still sits
// in the output register. A stalled receiver freezes the walk.
// Reset empties the table and drops any pending result; no clearing pass.
module keyed_list_table_insert_remove_search_unit #(
  parameter int CAPACITY = klt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = klt_pkg::KEY_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [klt_pkg::IN_W-1:0] s_tdata,   // action[1:0], key_word[65:2]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [klt_pkg::OUT_W-1:0] m_tdata,  // status[2:0], position[8:3]
  output logic                     m_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);

  klt_pkg::state_t state, state_next;

  logic [CW-1:0]                 count, count_next;
  logic [CW-1:0]                 pos, pos_next;
  logic [klt_pkg::ACTION_W-1:0]  op, op_next;
  logic [KEY_BITS-1:0]           key_q;

  logic                          ovalid, ovalid_next;
  logic [klt_pkg::STATUS_W-1:0]  ostatus, ostatus_next;
  logic [klt_pkg::POS_W-1:0]     opos, opos_next;
  logic                          olast, olast_next;

  logic [KEY_BITS-1:0]           in_key;
  logic [klt_pkg::ACTION_W-1:0]  in_action;
  logic [KEY_BITS-1:0]           cmp_key;
  logic                          accept, ofree, emit;
  logic                          do_load, do_shift, do_capture, do_advance;
  logic                          any_flag, rest_flag;

  logic [KEY_BITS-1:0]           cell_key [CAPACITY];
  logic [CAPACITY-1:0]           flags;
  klt_pkg::cell_ctl_t            ctl [CAPACITY];

  assign in_action = s_tdata[klt_pkg::ACTION_W-1:0];
  assign in_key    = s_tdata[klt_pkg::ACTION_W +: KEY_BITS];
  assign s_tready  = (state == klt_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign ofree     = !ovalid || m_tready;
  assign cmp_key   = (state == klt_pkg::ST_IDLE) ? in_key : key_q;
  assign any_flag  = |flags;
  assign rest_flag = |(flags >> 1);

  always_comb begin
    state_next   = state;
    count_next   = count;
    pos_next     = pos;
    op_next      = op;
    emit         = 1'b0;
    ostatus_next = ostatus;
    opos_next    = opos;
    olast_next   = olast;
    do_load      = 1'b0;
    do_shift     = 1'b0;
    do_capture   = 1'b0;
    do_advance   = 1'b0;
    case (state)
      klt_pkg::ST_IDLE: begin
        if (accept) begin
          op_next  = in_action;
          pos_next = '0;
          if (in_action == klt_pkg::ACT_INSERT) begin
            state_next = klt_pkg::ST_INS;
          end else if (in_action == klt_pkg::ACT_REMOVE ||
                       in_action == klt_pkg::ACT_SEARCH) begin
            do_capture = 1'b1;
            state_next = klt_pkg::ST_SCAN;
          end
        end
      end
      klt_pkg::ST_INS: begin
        if (ofree) begin
          emit       = 1'b1;
          olast_next = 1'b1;
          state_next = klt_pkg::ST_IDLE;
          if (count < CW'(CAPACITY)) begin
            do_load      = 1'b1;
            ostatus_next = klt_pkg::STAT_ADDED;
            opos_next    = klt_pkg::POS_W'(count);
            count_next   = count + CW'(1);
          end else begin
            ostatus_next = klt_pkg::STAT_FULL;
            opos_next    = '0;
          end
        end
      end
      klt_pkg::ST_SCAN: begin
        if (ofree) begin
          if (!any_flag) begin
            // only reached when nothing matched at all
            emit         = 1'b1;
            ostatus_next = klt_pkg::STAT_NOT_FOUND;
            opos_next    = '0;
            olast_next   = 1'b1;
            state_next   = klt_pkg::ST_IDLE;
          end else if (flags[0]) begin
            emit      = 1'b1;
            opos_next = klt_pkg::POS_W'(pos);
            if (op == klt_pkg::ACT_REMOVE) begin
              do_shift     = 1'b1;
              count_next   = count - CW'(1);
              ostatus_next = klt_pkg::STAT_REMOVED;
              olast_next   = 1'b1;
              state_next   = klt_pkg::ST_IDLE;
            end else begin
              ostatus_next = klt_pkg::STAT_MATCH;
              olast_next   = !rest_flag;
              if (rest_flag) begin
                do_advance = 1'b1;
                pos_next   = pos + CW'(1);
              end else begin
                state_next = klt_pkg::ST_IDLE;
              end
            end
          end else begin
            do_advance = 1'b1;
            pos_next   = pos + CW'(1);
          end
        end
      end
      default: begin
        state_next = klt_pkg::ST_IDLE;
      end
    endcase
    if (emit) begin
      ovalid_next = 1'b1;
    end else if (m_tready) begin
      ovalid_next = 1'b0;
    end else begin
      ovalid_next = ovalid;
    end
  end

  // per-cell controls: insert writes the cell at count, remove shifts
  // every cell at or above the matched position
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].load    = do_load && (count == CW'(i));
      ctl[i].shift   = do_shift && (CW'(i) >= pos);
      ctl[i].capture = do_capture;
      ctl[i].advance = do_advance;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_BITS-1:0] nbr_key;
    logic                nbr_flag;
    if (g == CAPACITY - 1) begin : g_top
      assign nbr_key  = '0;
      assign nbr_flag = 1'b0;
    end else begin : g_mid
      assign nbr_key  = cell_key[g+1];
      assign nbr_flag = flags[g+1];
    end
    klt_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl[g]),
      .valid    (CW'(g) < count),
      .cmp_key  (cmp_key),
      .nbr_key  (nbr_key),
      .nbr_flag (nbr_flag),
      .key      (cell_key[g]),
      .flag     (flags[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= klt_pkg::ST_IDLE;
      count  <= '0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      ovalid <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    op      <= op_next;
    ostatus <= ostatus_next;
    opos    <= opos_next;
    olast   <= olast_next;
    if (accept) begin
      key_q <= in_key;
    end
  end

  assign m_tvalid = ovalid;
  assign m_tlast  = olast;
  assign m_tdata  = {{(klt_pkg::OUT_W - klt_pkg::STATUS_W - klt_pkg::POS_W){1'b0}},
                     opos, ostatus};

endmodule

@@ src/klt_checker.sv @@
// Port-level checker for the keyed list table unit, bound to the top level.
// Depends on klt_pkg and the macros header.
`include "keyed_list_table_insert_remove_search_unit_macros.svh"

module klt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [klt_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tlast
);

  logic [klt_pkg::STATUS_W-1:0] status;
  logic [klt_pkg::POS_W-1:0]    position;

  assign status   = m_tdata[klt_pkg::STATUS_W-1:0];
  assign position = m_tdata[klt_pkg::STATUS_W +: klt_pkg::POS_W];

  `KLT_ASSERT_ALWAYS(a_rst_clears_out, clk, rst |=> !m_tvalid, "result valid after reset")
  `KLT_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled item changed")
  `KLT_ASSERT(a_status_code, clk, rst, m_tvalid |-> status <= klt_pkg::STAT_MATCH, "bad status code")
  `KLT_ASSERT(a_single_last, clk, rst, m_tvalid && status != klt_pkg::STAT_MATCH |-> m_tlast, "single result not marked last")
  `KLT_ASSERT(a_zero_pos, clk, rst, m_tvalid && (status == klt_pkg::STAT_FULL || status == klt_pkg::STAT_NOT_FOUND) |-> position == '0, "position not zero")

endmodule

bind keyed_list_table_insert_remove_search_unit klt_checker u_klt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
